/* sv/gcode_line_parser_unit_assert.svh */
// Assertion macros shared by the parser checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GCODE_LINE_PARSER_UNIT_ASSERT_SVH
`define GCODE_LINE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define GLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define GLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gcode_lp_pkg.sv */
// Shared types, codes and helpers of the G-code line parser.
// No dependencies; the parser, the top level and the checker import this package.
package gcode_lp_pkg;

    localparam int LINE_BYTES_DEF  = 64;
    localparam int FRAC_DIGITS_DEF = 3;

    // magnitude width, and width of an accumulate before saturation
    localparam int MAG_W = 31;
    localparam int SUM_W = 36;
    localparam int CODE_W = 10;
    localparam int CODE_SUM_W = 14;

    localparam logic [MAG_W-1:0]  MAG_MAX  = {MAG_W{1'b1}};
    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};
    localparam logic [CODE_W-1:0] CODE_G1   = 10'd1;
    localparam logic [CODE_W-1:0] CODE_G28  = 10'd28;
    localparam logic [CODE_W-1:0] CODE_M999 = 10'd999;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_G,
        PH_M,
        PH_XS,
        PH_XI,
        PH_XF,
        PH_YS,
        PH_YI,
        PH_YF
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MOVE,
        KIND_HOME,
        KIND_RESET
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_G,
        STAT_BAD_M
    } status_t;

    typedef struct packed {
        kind_t              command_kind;
        logic signed [31:0] x_milli;
        logic               x_valid;
        logic signed [31:0] y_milli;
        logic               y_valid;
        status_t            status;
    } cmd_t;

    // power of ten, used on constants only
    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    // clamp an accumulated magnitude to 2^31-1
    function automatic logic [MAG_W-1:0] sat_mag(input logic [SUM_W-1:0] s);
        if (s > SUM_W'(MAG_MAX))
        begin
            return MAG_MAX;
        end
        return s[MAG_W-1:0];
    endfunction

endpackage

/* sv/gcode_lp_byte_if.sv */
// Byte channel of the G-code line parser: valid/ready plus one character.
// Standalone interface, no dependencies.
interface gcode_lp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/gcode_lp_cmd_if.sv */
// Command channel of the G-code line parser: valid/ready plus command fields.
// Standalone interface, no dependencies.
interface gcode_lp_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command_kind;
    logic signed [31:0] x_milli;
    logic               x_valid;
    logic signed [31:0] y_milli;
    logic               y_valid;
    logic [1:0]         status;

    modport source (output valid, output command_kind, output x_milli, output x_valid,
                    output y_milli, output y_valid, output status, input ready);
    modport sink   (input valid, input command_kind, input x_milli, input x_valid,
                    input y_milli, input y_valid, input status, output ready);
endinterface

/* sv/gcode_lp_parser.sv */
// Parser state and one-byte update of the G-code line parser.
// Depends on gcode_lp_pkg.
module gcode_lp_parser import gcode_lp_pkg::*; #(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       emit,
    output cmd_t       cmd
);

    localparam int LC_W = $clog2(LINE_BYTES);
    localparam int FD_W = $clog2(FRAC_DIGITS + 1);
    localparam logic [LC_W-1:0]  LAST_COUNT = LC_W'(LINE_BYTES - 1);
    localparam logic [31:0]      INT_WEIGHT = pow10(FRAC_DIGITS);
    localparam logic [FD_W-1:0]  FD_FULL    = FD_W'(FRAC_DIGITS);

    // parser state
    logic [LC_W-1:0]   count_reg, count_next;
    phase_t            phase_reg, phase_next;
    logic              halted_reg, halted_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [MAG_W-1:0]  num_reg, num_next;
    logic              neg_reg, neg_next;
    logic [FD_W-1:0]   fd_reg, fd_next;
    kind_t             kind_reg, kind_next;
    logic [31:0]       cur_x_reg, cur_x_next;
    logic              cur_xv_reg, cur_xv_next;
    logic [31:0]       cur_y_reg, cur_y_next;
    logic              cur_yv_reg, cur_yv_next;
    status_t           stat_reg, stat_next;
    logic [31:0]       prior_x_reg, prior_x_next;
    logic              prior_xv_reg, prior_xv_next;
    logic [31:0]       prior_y_reg, prior_y_next;
    logic              prior_yv_reg, prior_yv_next;

    // values after closing the pending token
    kind_t             fin_kind;
    logic [31:0]       fin_x;
    logic              fin_xv;
    logic [31:0]       fin_y;
    logic              fin_yv;
    status_t           fin_stat;
    logic              fin_halted;
    logic [31:0]       num_signed;

    // digit arithmetic
    logic                  is_digit;
    logic                  is_eol;
    logic [3:0]            digit;
    logic [31:0]           frac_weight;
    logic [CODE_SUM_W-1:0] code_sum;
    logic [SUM_W-1:0]      int_sum;
    logic [SUM_W-1:0]      frac_sum;

    // classify the byte and form the digit accumulations
    always_comb
    begin
        is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
        is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
        digit    = rx_byte[3:0];
        frac_weight = '0;
        for (int i = 0; i < FRAC_DIGITS; i++)
        begin
            if (fd_reg == FD_W'(i))
            begin
                frac_weight = pow10(FRAC_DIGITS - 1 - i);
            end
        end
        code_sum = (CODE_SUM_W'(code_reg) << 3) + (CODE_SUM_W'(code_reg) << 1)
                 + CODE_SUM_W'(digit);
        int_sum  = (SUM_W'(num_reg) << 3) + (SUM_W'(num_reg) << 1)
                 + SUM_W'(digit) * SUM_W'(INT_WEIGHT);
        frac_sum = SUM_W'(num_reg) + SUM_W'(digit) * SUM_W'(frac_weight);
    end

    // close the pending token
    always_comb
    begin
        num_signed = neg_reg ? (32'd0 - {1'b0, num_reg}) : {1'b0, num_reg};
        fin_kind   = kind_reg;
        fin_x      = cur_x_reg;
        fin_xv     = cur_xv_reg;
        fin_y      = cur_y_reg;
        fin_yv     = cur_yv_reg;
        fin_stat   = stat_reg;
        fin_halted = halted_reg;
        unique case (phase_reg)
            PH_G:
            begin
                if (code_reg == CODE_G1)
                begin
                    fin_kind = KIND_MOVE;
                    if (!cur_xv_reg)
                    begin
                        fin_x  = prior_x_reg;
                        fin_xv = prior_xv_reg;
                    end
                    if (!cur_yv_reg)
                    begin
                        fin_y  = prior_y_reg;
                        fin_yv = prior_yv_reg;
                    end
                end
                else if (code_reg == CODE_G28)
                begin
                    fin_kind   = KIND_HOME;
                    fin_halted = 1'b1;
                end
                else
                begin
                    fin_stat   = STAT_BAD_G;
                    fin_halted = 1'b1;
                end
            end
            PH_M:
            begin
                if (code_reg == CODE_M999)
                begin
                    fin_kind   = KIND_RESET;
                    fin_halted = 1'b1;
                end
                else
                begin
                    fin_stat = STAT_BAD_M;
                end
            end
            PH_XS, PH_XI, PH_XF:
            begin
                fin_x  = num_signed;
                fin_xv = 1'b1;
            end
            PH_YS, PH_YI, PH_YF:
            begin
                fin_y  = num_signed;
                fin_yv = 1'b1;
            end
            default:
            begin
                fin_kind = kind_reg;
            end
        endcase
    end

    // next state for one accepted byte
    always_comb
    begin
        logic consumed;
        count_next    = count_reg;
        phase_next    = phase_reg;
        halted_next   = halted_reg;
        code_next     = code_reg;
        num_next      = num_reg;
        neg_next      = neg_reg;
        fd_next       = fd_reg;
        kind_next     = kind_reg;
        cur_x_next    = cur_x_reg;
        cur_xv_next   = cur_xv_reg;
        cur_y_next    = cur_y_reg;
        cur_yv_next   = cur_yv_reg;
        stat_next     = stat_reg;
        prior_x_next  = prior_x_reg;
        prior_xv_next = prior_xv_reg;
        prior_y_next  = prior_y_reg;
        prior_yv_next = prior_yv_reg;
        consumed      = 1'b0;

        if (step)
        begin
            if (is_eol || (count_reg >= LAST_COUNT))
            begin
                // line end after a non-empty line: hand the command over as prior
                if (is_eol && (count_reg != '0))
                begin
                    prior_x_next  = (halted_reg ? cur_xv_reg : fin_xv)
                                  ? (halted_reg ? cur_x_reg : fin_x) : 32'd0;
                    prior_xv_next = halted_reg ? cur_xv_reg : fin_xv;
                    prior_y_next  = (halted_reg ? cur_yv_reg : fin_yv)
                                  ? (halted_reg ? cur_y_reg : fin_y) : 32'd0;
                    prior_yv_next = halted_reg ? cur_yv_reg : fin_yv;
                end
                // restart the line, unless an empty line end is simply dropped
                if (!is_eol || (count_reg != '0))
                begin
                    count_next  = '0;
                    phase_next  = PH_IDLE;
                    halted_next = 1'b0;
                    code_next   = '0;
                    num_next    = '0;
                    neg_next    = 1'b0;
                    fd_next     = '0;
                    kind_next   = KIND_NONE;
                    cur_x_next  = '0;
                    cur_xv_next = 1'b0;
                    cur_y_next  = '0;
                    cur_yv_next = 1'b0;
                    stat_next   = STAT_OK;
                end
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if (!halted_reg)
                begin
                    // extend the token in progress
                    if (rx_byte != CH_NUL)
                    begin
                        unique case (phase_reg)
                            PH_G, PH_M:
                            begin
                                if (is_digit)
                                begin
                                    consumed  = 1'b1;
                                    code_next = (code_sum > CODE_SUM_W'(CODE_MAX))
                                              ? CODE_MAX : code_sum[CODE_W-1:0];
                                end
                            end
                            PH_XS, PH_YS:
                            begin
                                if (rx_byte == CH_MINUS)
                                begin
                                    consumed   = 1'b1;
                                    neg_next   = 1'b1;
                                    phase_next = (phase_reg == PH_XS) ? PH_XI : PH_YI;
                                end
                                else if (is_digit)
                                begin
                                    consumed   = 1'b1;
                                    num_next   = sat_mag(int_sum);
                                    phase_next = (phase_reg == PH_XS) ? PH_XI : PH_YI;
                                end
                                else if (rx_byte == CH_DOT)
                                begin
                                    consumed   = 1'b1;
                                    phase_next = (phase_reg == PH_XS) ? PH_XF : PH_YF;
                                end
                            end
                            PH_XI, PH_YI:
                            begin
                                if (is_digit)
                                begin
                                    consumed = 1'b1;
                                    num_next = sat_mag(int_sum);
                                end
                                else if (rx_byte == CH_DOT)
                                begin
                                    consumed   = 1'b1;
                                    phase_next = (phase_reg == PH_XI) ? PH_XF : PH_YF;
                                end
                            end
                            PH_XF, PH_YF:
                            begin
                                if (is_digit)
                                begin
                                    consumed = 1'b1;
                                    if (fd_reg < FD_FULL)
                                    begin
                                        fd_next  = fd_reg + 1'b1;
                                        num_next = sat_mag(frac_sum);
                                    end
                                end
                            end
                            default:
                            begin
                                consumed = 1'b0;
                            end
                        endcase
                    end

                    // close the token and start a new one from this byte
                    if (!consumed)
                    begin
                        kind_next   = fin_kind;
                        cur_x_next  = fin_x;
                        cur_xv_next = fin_xv;
                        cur_y_next  = fin_y;
                        cur_yv_next = fin_yv;
                        stat_next   = fin_stat;
                        halted_next = fin_halted || (rx_byte == CH_NUL);
                        phase_next  = PH_IDLE;
                        if (!fin_halted && (rx_byte != CH_NUL))
                        begin
                            priority case (rx_byte)
                                CH_G:
                                begin
                                    phase_next = PH_G;
                                    code_next  = '0;
                                end
                                CH_M:
                                begin
                                    phase_next = PH_M;
                                    code_next  = '0;
                                end
                                CH_X, CH_Y:
                                begin
                                    phase_next = (rx_byte == CH_X) ? PH_XS : PH_YS;
                                    num_next   = '0;
                                    neg_next   = 1'b0;
                                    fd_next    = '0;
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    // command emitted at a line end
    always_comb
    begin
        emit = step && is_eol && (count_reg != '0);
        cmd.command_kind = halted_reg ? kind_reg : fin_kind;
        cmd.x_valid      = halted_reg ? cur_xv_reg : fin_xv;
        cmd.x_milli      = cmd.x_valid ? (halted_reg ? cur_x_reg : fin_x) : 32'sd0;
        cmd.y_valid      = halted_reg ? cur_yv_reg : fin_yv;
        cmd.y_milli      = cmd.y_valid ? (halted_reg ? cur_y_reg : fin_y) : 32'sd0;
        cmd.status       = halted_reg ? stat_reg : fin_stat;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            phase_reg    <= PH_IDLE;
            halted_reg   <= 1'b0;
            code_reg     <= '0;
            num_reg      <= '0;
            neg_reg      <= 1'b0;
            fd_reg       <= '0;
            kind_reg     <= KIND_NONE;
            cur_x_reg    <= '0;
            cur_xv_reg   <= 1'b0;
            cur_y_reg    <= '0;
            cur_yv_reg   <= 1'b0;
            stat_reg     <= STAT_OK;
            prior_x_reg  <= '0;
            prior_xv_reg <= 1'b0;
            prior_y_reg  <= '0;
            prior_yv_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            halted_reg   <= halted_next;
            code_reg     <= code_next;
            num_reg      <= num_next;
            neg_reg      <= neg_next;
            fd_reg       <= fd_next;
            kind_reg     <= kind_next;
            cur_x_reg    <= cur_x_next;
            cur_xv_reg   <= cur_xv_next;
            cur_y_reg    <= cur_y_next;
            cur_yv_reg   <= cur_yv_next;
            stat_reg     <= stat_next;
            prior_x_reg  <= prior_x_next;
            prior_xv_reg <= prior_xv_next;
            prior_y_reg  <= prior_y_next;
            prior_yv_reg <= prior_yv_next;
        end
    end

endmodule

/* sv/gcode_line_parser_unit.sv */
// Top level of the streaming G-code line parser: input byte register,
// parser core and command output register. Depends on gcode_lp_pkg,
// gcode_lp_byte_if, gcode_lp_cmd_if and gcode_lp_parser.
//
// Usage:
//   rx  : one ASCII byte per item (valid/ready). Bytes are parsed as they
//         arrive; a line is never buffered.
//   cmd : one command item per non-empty line, emitted on CR or LF, with
//         kind, X and Y in thousandths and their valid flags, and a status.
//   Path: a line-end byte is taken into the byte register, processed by
//         the parser core, and its command is held in the command register.
//   Throughput: one byte per cycle when not stalled; the per-byte update is
//         one pass of logic between the byte register and the parser state.
//   Stall: the command register holds while cmd.ready is low; the byte
//         register still takes one more byte, and rx.ready falls only when
//         both registers are full.
//   Reset: rst_n clears the parser, the previous command (axes invalid)
//         and both register valid flags; rx.ready is high right after reset.
module gcode_line_parser_unit import gcode_lp_pkg::*; #(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    gcode_lp_byte_if.sink   rx,
    gcode_lp_cmd_if.source  cmd
);

    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       cmd_valid_reg, cmd_valid_next;
    cmd_t       cmd_reg, cmd_next;
    logic       advance;
    logic       step;
    logic       emit;
    cmd_t       core_cmd;

    gcode_lp_parser #(
        .LINE_BYTES  (LINE_BYTES),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (byte_reg),
        .emit    (emit),
        .cmd     (core_cmd)
    );

    // advance whenever the output slot is free or being drained
    always_comb
    begin
        advance  = !cmd_valid_reg || cmd.ready;
        step     = byte_valid_reg && advance;
        rx.ready = !byte_valid_reg || advance;

        byte_valid_next = byte_valid_reg;
        byte_next       = byte_reg;
        if (rx.ready)
        begin
            byte_valid_next = rx.valid;
            byte_next       = rx.rx_byte;
        end

        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (advance)
        begin
            cmd_valid_next = step && emit;
            cmd_next       = core_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            cmd_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            cmd_valid_reg  <= cmd_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        cmd_reg  <= cmd_next;
    end

    // drive the command channel
    always_comb
    begin
        cmd.valid        = cmd_valid_reg;
        cmd.command_kind = cmd_reg.command_kind;
        cmd.x_milli      = cmd_reg.x_milli;
        cmd.x_valid      = cmd_reg.x_valid;
        cmd.y_milli      = cmd_reg.y_milli;
        cmd.y_valid      = cmd_reg.y_valid;
        cmd.status       = cmd_reg.status;
    end

endmodule

/* sv/gcode_lp_checker.sv */
// Port-level checks of the G-code line parser, bound to the top level.
// Depends on gcode_lp_pkg and gcode_line_parser_unit_assert.svh.
`include "gcode_line_parser_unit_assert.svh"

module gcode_lp_checker import gcode_lp_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  command_kind,
    input logic [31:0] x_milli,
    input logic        x_valid,
    input logic [31:0] y_milli,
    input logic        y_valid,
    input logic [1:0]  status
);

    // hold a stalled command
    `GLP_ASSERT_NXT(a_cmd_hold, cmd_valid && !cmd_ready, cmd_valid && $stable(x_milli) && $stable(y_milli) && $stable(command_kind), "stalled command changed or dropped")

    // a new command must trace back to a byte accepted on rx
    `GLP_ASSERT_IMP(a_cmd_source, $rose(cmd_valid), $past(rx_valid && rx_ready, 2), "command without a byte")

    // an invalid axis reads as zero
    `GLP_ASSERT_IMP(a_axis_zero, cmd_valid, (x_valid || (x_milli == 32'd0)) && (y_valid || (y_milli == 32'd0)), "invalid axis not zero")

    // saturation keeps coordinates off the most negative value; status stays coded
    `GLP_ASSERT_IMP(a_range, cmd_valid, (x_milli != 32'h8000_0000) && (y_milli != 32'h8000_0000) && (status != 2'd3) && ((command_kind == KIND_NONE) || (command_kind == KIND_MOVE) || (command_kind == KIND_HOME) || (command_kind == KIND_RESET)), "coordinate or status out of range")

endmodule

bind gcode_line_parser_unit gcode_lp_checker u_gcode_lp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .command_kind (cmd.command_kind),
    .x_milli      (cmd.x_milli),
    .x_valid      (cmd.x_valid),
    .y_milli      (cmd.y_milli),
    .y_valid      (cmd.y_valid),
    .status       (cmd.status)
);
